/* src/generation_tagged_slot_allocator_assert.svh */
// assertion macros used by the port checker
`ifndef GENERATION_TAGGED_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATION_TAGGED_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* src/gtsa_pkg.sv */
// package: sizes, codes and structs of the slot allocator
`timescale 1ns / 1ps
package gtsa_pkg;

  localparam int SLOTS     = 1024;   // power of two
  localparam int GEN_SHIFT = 12;

  localparam int IDX_W     = $clog2(SLOTS);
  localparam int HEAD_W    = IDX_W + 1;
  localparam int IDENT_W   = 31;
  localparam int SUM_W     = IDENT_W + 1;
  localparam int RUNS_W    = 32;
  localparam int OUT_IDX_W = 10;
  localparam int MODE_W    = 2;
  localparam int STAT_W    = 2;

  localparam logic [HEAD_W-1:0] NULL_SLOT = HEAD_W'(SLOTS);
  localparam logic [SUM_W-1:0]  GEN_INC   = SUM_W'(1) << GEN_SHIFT;
  localparam logic [SUM_W-1:0]  GEN_MASK  = ~SUM_W'(SLOTS - 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_RUN    = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BAD    = 2'd1,
    STAT_NOFREE = 2'd2
  } status_t;

  // the table keeps free or runnable; running is the current-slot register
  typedef enum logic [1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNABLE = 2'd1
  } slot_status_t;

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    slot_status_t       status;
    logic [IDENT_W-1:0] parent;
    logic [RUNS_W-1:0]  runs;
    logic [HEAD_W-1:0]  next;
  } slot_entry_t;

  typedef struct packed {
    mode_t              mode;
    logic [IDENT_W-1:0] env_ident;
    logic [IDENT_W-1:0] parent_ident;
    logic               check_perm;
  } req_t;

  typedef struct packed {
    logic [HEAD_W-1:0]  head;
    logic [HEAD_W-1:0]  fill;
    logic [HEAD_W-1:0]  current;
    logic [IDENT_W-1:0] cur_ident;
  } ctx_t;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [IDENT_W-1:0]   ident;
    logic [OUT_IDX_W-1:0] slot_index;
    logic [RUNS_W-1:0]    runs;
  } result_t;

  typedef struct packed {
    logic        we;
    slot_entry_t wentry;
    ctx_t        ctx;
    result_t     result;
  } upd_t;

endpackage

/* src/gtsa_if.sv */
// request and result channel interfaces
`timescale 1ns / 1ps
interface gtsa_in_if;
  logic                        valid;
  logic                        ready;
  logic [gtsa_pkg::MODE_W-1:0]  mode;
  logic [gtsa_pkg::IDENT_W-1:0] env_ident;
  logic [gtsa_pkg::IDENT_W-1:0] parent_ident;
  logic                        check_perm;

  modport source (output valid, mode, env_ident, parent_ident, check_perm, input ready);
  modport sink   (input valid, mode, env_ident, parent_ident, check_perm, output ready);
endinterface

interface gtsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [gtsa_pkg::STAT_W-1:0]    status;
  logic                          found;
  logic [gtsa_pkg::IDENT_W-1:0]   result_ident;
  logic [gtsa_pkg::OUT_IDX_W-1:0] slot_index;
  logic [gtsa_pkg::RUNS_W-1:0]    runs;

  modport source (output valid, status, found, result_ident, slot_index, runs, input ready);
  modport sink   (input valid, status, found, result_ident, slot_index, runs, output ready);
endinterface

/* src/gtsa_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module gtsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/gtsa_slot_logic.sv */
// per-operation evaluation: entry update, free list, current slot and result
`timescale 1ns / 1ps
module gtsa_slot_logic (
  input  gtsa_pkg::req_t                req,
  input  logic [gtsa_pkg::IDX_W-1:0]    idx,
  input  gtsa_pkg::slot_entry_t         rd,
  input  gtsa_pkg::ctx_t                ctx,
  output gtsa_pkg::upd_t                upd
);

  logic                          fresh;
  logic                          live;
  logic [gtsa_pkg::HEAD_W-1:0]   idx_ext;
  logic [gtsa_pkg::IDENT_W-1:0]  ident_old;
  logic [gtsa_pkg::SUM_W-1:0]    gen_sum;
  logic [gtsa_pkg::SUM_W-1:0]    gen;
  logic [gtsa_pkg::IDENT_W-1:0]  new_ident;
  logic                          cur_valid;
  logic                          cur_hit;

  assign idx_ext   = gtsa_pkg::HEAD_W'(idx);
  // slots at or above the fill mark were never allocated: zero ident, free, next is idx+1
  assign fresh     = idx_ext >= ctx.fill;
  assign live      = !fresh && (rd.status != gtsa_pkg::SLOT_FREE);
  assign ident_old = fresh ? '0 : rd.ident;
  assign gen_sum   = gtsa_pkg::SUM_W'(ident_old) + gtsa_pkg::GEN_INC;

  always_comb begin
    gen = gen_sum & gtsa_pkg::GEN_MASK;
    // fall back to base generation on wrap into the sign bit
    if (gen == '0 || gen[gtsa_pkg::IDENT_W]) begin
      gen = gtsa_pkg::GEN_INC;
    end
  end

  assign new_ident = gtsa_pkg::IDENT_W'(gen | gtsa_pkg::SUM_W'(idx));
  assign cur_valid = ctx.current < gtsa_pkg::NULL_SLOT;
  assign cur_hit   = idx_ext == ctx.current;

  always_comb begin
    upd                   = '0;
    upd.wentry            = rd;
    upd.ctx               = ctx;
    upd.result.status     = gtsa_pkg::STAT_BAD;

    case (req.mode)
      gtsa_pkg::MODE_ALLOC: begin
        if (ctx.head >= gtsa_pkg::NULL_SLOT) begin
          upd.result.status = gtsa_pkg::STAT_NOFREE;
        end else begin
          upd.we                = 1'b1;
          upd.wentry.ident      = new_ident;
          upd.wentry.status     = gtsa_pkg::SLOT_RUNNABLE;
          upd.wentry.parent     = req.parent_ident;
          upd.wentry.runs       = '0;
          upd.ctx.head          = fresh ? idx_ext + gtsa_pkg::HEAD_W'(1) : rd.next;
          upd.ctx.fill          = fresh ? ctx.fill + gtsa_pkg::HEAD_W'(1) : ctx.fill;
          if (cur_hit) begin
            upd.ctx.cur_ident = new_ident;
          end
          upd.result.status     = gtsa_pkg::STAT_OK;
          upd.result.found      = 1'b1;
          upd.result.ident      = new_ident;
          upd.result.slot_index = gtsa_pkg::OUT_IDX_W'(idx);
        end
      end
      gtsa_pkg::MODE_FREE: begin
        if (live) begin
          upd.we                = 1'b1;
          upd.wentry.status     = gtsa_pkg::SLOT_FREE;
          upd.wentry.next       = ctx.head;
          upd.ctx.head          = idx_ext;
          upd.result.status     = gtsa_pkg::STAT_OK;
          upd.result.found      = 1'b1;
          upd.result.ident      = rd.ident;
          upd.result.slot_index = gtsa_pkg::OUT_IDX_W'(idx);
        end
      end
      gtsa_pkg::MODE_LOOKUP: begin
        if (req.env_ident == '0) begin
          // zero means the current slot, no permission check
          upd.result.status = gtsa_pkg::STAT_OK;
          if (cur_valid) begin
            upd.result.found      = 1'b1;
            upd.result.ident      = ctx.cur_ident;
            upd.result.slot_index = gtsa_pkg::OUT_IDX_W'(ctx.current);
          end
        end else if (live && rd.ident == req.env_ident &&
                     (!req.check_perm || cur_hit ||
                      (cur_valid && rd.parent == ctx.cur_ident))) begin
          upd.result.status     = gtsa_pkg::STAT_OK;
          upd.result.found      = 1'b1;
          upd.result.ident      = rd.ident;
          upd.result.slot_index = gtsa_pkg::OUT_IDX_W'(idx);
        end
      end
      gtsa_pkg::MODE_RUN: begin
        if (live) begin
          upd.we                = 1'b1;
          upd.wentry.runs       = rd.runs + gtsa_pkg::RUNS_W'(1);
          upd.ctx.current       = idx_ext;
          upd.ctx.cur_ident     = rd.ident;
          upd.result.status     = gtsa_pkg::STAT_OK;
          upd.result.found      = 1'b1;
          upd.result.ident      = rd.ident;
          upd.result.slot_index = gtsa_pkg::OUT_IDX_W'(idx);
          upd.result.runs       = rd.runs + gtsa_pkg::RUNS_W'(1);
        end
      end
      default: begin
        upd.result.status = gtsa_pkg::STAT_BAD;
      end
    endcase
  end

endmodule

/* src/generation_tagged_slot_allocator.sv */
// top level: slot table sequencer around the slot memory
//
// Generational slot table with a LIFO free list. Requests arrive on in_ch
// (allocate, free, look up, run) and each gives exactly one result on out_ch.
// Both channels transfer when valid and ready are high at a rising edge.
// For each item, the transfer in IDLE issues the read of the slot entry; EXEC then
// modifies it, writes it back and loads the result register, and a new request is
// taken once the state is back in IDLE. No new request is taken before the last one
// is through, since only one request is in flight. The result is offered from the
// result register once EXEC has written back.
// If the receiver stalls, the result register holds; one further request is
// still taken and waits at the write-back step until the result register
// frees up, so in_ready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the result register, sets the free
// list head to slot zero and clears the current slot. A fill counter marks
// which slots were ever allocated, so the table needs no clearing pass and
// requests are taken in the first cycle after reset.
`timescale 1ns / 1ps
module generation_tagged_slot_allocator (
  input  logic       clk,
  input  logic       rst_n,
  gtsa_in_if.sink    in_ch,
  gtsa_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                     state_r, state_nxt;
  gtsa_pkg::req_t             req_r, req_nxt;
  logic [gtsa_pkg::IDX_W-1:0] idx_r, idx_nxt;
  gtsa_pkg::ctx_t             ctx_r, ctx_nxt;
  logic                       out_valid_r, out_valid_nxt;
  gtsa_pkg::result_t          out_res_r, out_res_nxt;

  logic                       ram_re;
  logic                       ram_we;
  logic [gtsa_pkg::IDX_W-1:0] ram_raddr;
  gtsa_pkg::slot_entry_t      ram_rdata;
  gtsa_pkg::upd_t             upd;

  assign ram_raddr = (in_ch.mode == gtsa_pkg::MODE_ALLOC) ?
                     ctx_r.head[gtsa_pkg::IDX_W-1:0] :
                     in_ch.env_ident[gtsa_pkg::IDX_W-1:0];

  gtsa_ram #(
    .WIDTH ($bits(gtsa_pkg::slot_entry_t)),
    .DEPTH (gtsa_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (upd.wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gtsa_slot_logic u_slot_logic (
    .req (req_r),
    .idx (idx_r),
    .rd  (ram_rdata),
    .ctx (ctx_r),
    .upd (upd)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    ctx_nxt       = ctx_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    ram_re        = 1'b0;
    ram_we        = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ram_re               = 1'b1;
          req_nxt.mode         = gtsa_pkg::mode_t'(in_ch.mode);
          req_nxt.env_ident    = in_ch.env_ident;
          req_nxt.parent_ident = in_ch.parent_ident;
          req_nxt.check_perm   = in_ch.check_perm;
          idx_nxt              = ram_raddr;
          state_nxt            = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // write back only once the result register can take the answer
        if (!out_valid_r || out_ch.ready) begin
          ram_we        = upd.we;
          ctx_nxt       = upd.ctx;
          out_res_nxt   = upd.result;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      ctx_r.head      <= '0;
      ctx_r.fill      <= '0;
      ctx_r.current   <= gtsa_pkg::NULL_SLOT;
      ctx_r.cur_ident <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.found        = out_res_r.found;
  assign out_ch.result_ident = out_res_r.ident;
  assign out_ch.slot_index   = out_res_r.slot_index;
  assign out_ch.runs         = out_res_r.runs;

endmodule

/* src/gtsa_port_checker.sv */
// port-level checker for the slot allocator, bound to the top level
`timescale 1ns / 1ps
`include "generation_tagged_slot_allocator_assert.svh"
module gtsa_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gtsa_pkg::STAT_W-1:0]    out_status,
  input logic                          out_found,
  input logic [gtsa_pkg::IDENT_W-1:0]   out_result_ident,
  input logic [gtsa_pkg::OUT_IDX_W-1:0] out_slot_index,
  input logic [gtsa_pkg::RUNS_W-1:0]    out_runs
);

  // stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // one request in flight: ready drops after each input transfer
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  // no slot returned means empty payload
  `ASSERT_IMPLY(a_none_is_zero, clk, rst_n, out_valid && !out_found, out_result_ident == '0 && out_slot_index == '0 && out_runs == '0)
  // a failing status never returns a slot
  `ASSERT_IMPLY(a_fail_not_found, clk, rst_n, out_valid && out_status != gtsa_pkg::STAT_OK, !out_found)
  // a new result only follows a write-back cycle
  `ASSERT_IMPLY(a_result_after_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind generation_tagged_slot_allocator gtsa_port_checker u_gtsa_port_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_found        (out_ch.found),
  .out_result_ident (out_ch.result_ident),
  .out_slot_index   (out_ch.slot_index),
  .out_runs         (out_ch.runs)
);

/* tb/tb_generation_tagged_slot_allocator.sv */
// testbench for the generational slot allocator: predictor, scoreboard and request drivers
`timescale 1ns / 1ps
module tb_generation_tagged_slot_allocator;
  import gtsa_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum logic [1:0] {
    SL_FREE     = 2'd0,
    SL_RUNNABLE = 2'd1,
    SL_RUNNING  = 2'd2
  } slot_state_t;

  class slot_table_predictor;
    logic [IDENT_W-1:0] ident_tab [SLOTS];
    slot_state_t        state_tab [SLOTS];
    logic [IDENT_W-1:0] parent_tab[SLOTS];
    logic [RUNS_W-1:0]  runs_tab  [SLOTS];
    logic [HEAD_W-1:0]  link_tab  [SLOTS];
    logic [HEAD_W-1:0]  head;
    logic [HEAD_W-1:0]  cur;
    result_t            expected_q[$];
    int                 errors;
    int                 mode_cnt[4];
    int                 stat_cnt[4];
    int                 perm_hits;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        ident_tab[i]  = '0;
        state_tab[i]  = SL_FREE;
        parent_tab[i] = '0;
        runs_tab[i]   = '0;
        link_tab[i]   = HEAD_W'(i + 1);
      end
      head = '0;
      cur  = NULL_SLOT;
      errors = 0;
      perm_hits = 0;
      foreach (mode_cnt[i]) mode_cnt[i] = 0;
      foreach (stat_cnt[i]) stat_cnt[i] = 0;
    endfunction

    function result_t answer(status_t s, logic f, logic [IDENT_W-1:0] id,
                             logic [HEAD_W-1:0] idx, logic [RUNS_W-1:0] rn);
      result_t r;
      r.status     = s;
      r.found      = f;
      r.ident      = id;
      r.slot_index = idx[OUT_IDX_W-1:0];
      r.runs       = rn;
      return r;
    endfunction

    // work out the answer to one accepted request and update the table
    function void predict(mode_t m, logic [IDENT_W-1:0] id, logic [IDENT_W-1:0] par,
                          logic perm);
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] ci;
      logic [SUM_W-1:0] gen;
      result_t          r;
      mode_cnt[m]++;
      idx = id[IDX_W-1:0];
      ci  = cur[IDX_W-1:0];
      if (m == MODE_ALLOC) begin
        if (head == NULL_SLOT) begin
          r = answer(STAT_NOFREE, 1'b0, '0, '0, '0);
        end else begin
          idx = head[IDX_W-1:0];
          gen = ({1'b0, ident_tab[idx]} + GEN_INC) & GEN_MASK;
          // fall back to the base generation when the sign bit would be set
          if (gen == '0 || gen[SUM_W-1]) gen = GEN_INC;
          ident_tab[idx]  = gen[IDENT_W-1:0] | IDENT_W'(idx);
          parent_tab[idx] = par;
          state_tab[idx]  = SL_RUNNABLE;
          runs_tab[idx]   = '0;
          head            = link_tab[idx];
          r = answer(STAT_OK, 1'b1, ident_tab[idx], HEAD_W'(idx), '0);
        end
      end else if (m == MODE_LOOKUP && id == '0) begin
        // zero means the current slot, no permission check
        if (cur == NULL_SLOT) r = answer(STAT_OK, 1'b0, '0, '0, '0);
        else r = answer(STAT_OK, 1'b1, ident_tab[ci], cur, '0);
      end else if (state_tab[idx] == SL_FREE) begin
        r = answer(STAT_BAD, 1'b0, '0, '0, '0);
      end else if (m == MODE_FREE) begin
        state_tab[idx] = SL_FREE;
        link_tab[idx]  = head;
        head           = HEAD_W'(idx);
        r = answer(STAT_OK, 1'b1, ident_tab[idx], HEAD_W'(idx), '0);
      end else if (m == MODE_LOOKUP) begin
        if (ident_tab[idx] != id) begin
          r = answer(STAT_BAD, 1'b0, '0, '0, '0);
        end else if (perm && HEAD_W'(idx) != cur &&
                     (cur == NULL_SLOT || parent_tab[idx] != ident_tab[ci])) begin
          r = answer(STAT_BAD, 1'b0, '0, '0, '0);
        end else begin
          if (perm) perm_hits++;
          r = answer(STAT_OK, 1'b1, ident_tab[idx], HEAD_W'(idx), '0);
        end
      end else begin
        // the previous slot is demoted only if it is still marked running
        if (cur != NULL_SLOT && state_tab[ci] == SL_RUNNING) state_tab[ci] = SL_RUNNABLE;
        cur            = HEAD_W'(idx);
        state_tab[idx] = SL_RUNNING;
        runs_tab[idx]  = runs_tab[idx] + 1'b1;
        r = answer(STAT_OK, 1'b1, ident_tab[idx], HEAD_W'(idx), runs_tab[idx]);
      end
      stat_cnt[r.status]++;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
      errors++;
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
    endtask

    task compare(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(got.ident), 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.found !== want.found)
        report_mismatch("found", 64'(got.found), 64'(want.found));
      if (got.ident !== want.ident)
        report_mismatch("result_ident", 64'(got.ident), 64'(want.ident));
      if (got.slot_index !== want.slot_index)
        report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
      if (got.runs !== want.runs)
        report_mismatch("runs", 64'(got.runs), 64'(want.runs));
    endtask

    task flag_leftover();
      if (expected_q.size() != 0)
        report_mismatch("results never returned", 64'(expected_q.size()), 64'd0);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  gtsa_in_if  in_ch();
  gtsa_out_if out_ch();

  generation_tagged_slot_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  slot_table_predictor sb = new();
  bit steady;
  bit hold_request;
  int items_sent;
  int idle_cycles;

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [IDENT_W-1:0] live_ident();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      int j;
      j = (start + k) % SLOTS;
      if (sb.state_tab[j] != SL_FREE) return sb.ident_tab[j];
    end
    return IDENT_W'($urandom());
  endfunction

  function automatic logic [IDENT_W-1:0] current_ident();
    if (sb.cur == NULL_SLOT) return live_ident();
    return sb.ident_tab[sb.cur[IDX_W-1:0]];
  endfunction

  function automatic logic [IDENT_W-1:0] pick_target(mode_t m);
    int r;
    logic [IDENT_W-1:0] id;
    r  = $urandom_range(0, 99);
    id = live_ident();
    if (m == MODE_LOOKUP) begin
      if (r < 50) return id;
      // stale: same slot, some generation bit flipped
      if (r < 65) return id ^ (IDENT_W'(1) << $urandom_range(GEN_SHIFT, IDENT_W - 1));
      if (r < 75) return '0;
      if (r < 85) return current_ident();
      return IDENT_W'($urandom());
    end
    if (r < 80) return id;
    // free and run look only at the index bits
    if (r < 90) return {(IDENT_W - IDX_W)'($urandom()), id[IDX_W-1:0]};
    return IDENT_W'($urandom());
  endfunction

  function automatic logic [IDENT_W-1:0] pick_parent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return current_ident();
    if (r < 75) return IDENT_W'($urandom());
    if (r < 85) return '0;
    if (r < 90) return '1;
    return live_ident();
  endfunction

  task automatic send_request(mode_t m, logic [IDENT_W-1:0] id, logic [IDENT_W-1:0] par,
                              logic perm);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode         = m;
    in_ch.env_ident    = id;
    in_ch.parent_ident = par;
    in_ch.check_perm   = perm;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.predict(m, id, par, perm);
    items_sent++;
    if (items_sent % 150 == 0) steady = !steady;
  endtask

  task automatic random_request(int w_alloc, int w_free, int w_lookup);
    int    r;
    mode_t m;
    r = $urandom_range(0, 99);
    if (r < w_alloc) m = MODE_ALLOC;
    else if (r < w_alloc + w_free) m = MODE_FREE;
    else if (r < w_alloc + w_free + w_lookup) m = MODE_LOOKUP;
    else m = MODE_RUN;
    send_request(m, pick_target(m), pick_parent(), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_directed();
    send_request(MODE_LOOKUP, 31'h0000_0000, 31'h0000_0000, 1'b0); // no current slot
    send_request(MODE_LOOKUP, 31'h0000_0000, 31'h7fff_ffff, 1'b1);
    send_request(MODE_RUN,    31'h0000_0005, 31'h0000_0000, 1'b0); // run of a free slot
    send_request(MODE_FREE,   31'h0000_0007, 31'h0000_0000, 1'b0); // free of a free slot
    send_request(MODE_ALLOC,  31'h7fff_ffff, 31'h0000_0000, 1'b1);
    send_request(MODE_ALLOC,  31'h0000_0000, 31'h7fff_ffff, 1'b0);
    send_request(MODE_ALLOC,  31'h0000_0000, 31'h0000_1000, 1'b0); // child of slot zero
    send_request(MODE_LOOKUP, 31'h0000_1001, 31'h0000_0000, 1'b0);
    send_request(MODE_LOOKUP, 31'h0000_1001, 31'h0000_0000, 1'b1); // permission, no current
    send_request(MODE_LOOKUP, 31'h0000_2001, 31'h0000_0000, 1'b0); // stale
    send_request(MODE_LOOKUP, 31'h7fff_ffff, 31'h0000_0000, 1'b0);
    send_request(MODE_RUN,    31'h0000_1000, 31'h0000_0000, 1'b0);
    send_request(MODE_RUN,    31'h0000_1000, 31'h0000_0000, 1'b0); // current again
    send_request(MODE_LOOKUP, 31'h0000_1002, 31'h0000_0000, 1'b1);
    send_request(MODE_LOOKUP, 31'h0000_1001, 31'h0000_0000, 1'b1);
    send_request(MODE_LOOKUP, 31'h0000_1000, 31'h0000_0000, 1'b1);
    send_request(MODE_LOOKUP, 31'h0000_0000, 31'h0000_0000, 1'b1);
    send_request(MODE_RUN,    31'h7fff_fc01, 31'h0000_0000, 1'b0); // demotes slot zero
    send_request(MODE_FREE,   31'h0000_1001, 31'h0000_0000, 1'b0); // free of the current slot
    send_request(MODE_LOOKUP, 31'h0000_0000, 31'h0000_0000, 1'b0);
    send_request(MODE_LOOKUP, 31'h0000_1001, 31'h0000_0000, 1'b1);
    send_request(MODE_ALLOC,  31'h0000_0000, 31'h5555_5555, 1'b0); // next generation
    send_request(MODE_RUN,    31'h0000_2001, 31'h0000_0000, 1'b0);
    send_request(MODE_FREE,   31'h0000_1001, 31'h0000_0000, 1'b0);
  endtask

  // result side
  initial begin
    result_t got;
    int      gap;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap();
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.status     = status_t'(out_ch.status);
      got.found      = out_ch.found;
      got.ident      = out_ch.result_ident;
      got.slot_index = out_ch.slot_index;
      got.runs       = out_ch.runs;
      sb.compare(got);
    end
  end

  // no transfer on either side for too long ends the run
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_ALLOC;
    in_ch.env_ident    = '0;
    in_ch.parent_ident = '0;
    in_ch.check_perm   = 1'b0;
    out_ch.ready       = 1'b0;
    steady             = 1'b0;
    hold_request       = 1'b0;
    items_sent         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    for (int n = 0; n < 260; n++) begin
      // long receiver stall while requests keep coming
      if (n == 100) hold_request = 1'b1;
      random_request(30, 15, 35);
    end
    // pause until every answer is back
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    while (sb.head != NULL_SLOT) random_request(80, 0, 10);
    repeat (12) random_request(60, 0, 20);
    repeat (200) random_request(10, 55, 20);
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftover();
    $display("run covered %0d requests: %0d allocate, %0d free, %0d lookup, %0d run",
             items_sent, sb.mode_cnt[MODE_ALLOC], sb.mode_cnt[MODE_FREE],
             sb.mode_cnt[MODE_LOOKUP], sb.mode_cnt[MODE_RUN]);
    $display("answers: %0d ok, %0d bad identifier, %0d table full, %0d permitted lookups",
             sb.stat_cnt[STAT_OK], sb.stat_cnt[STAT_BAD], sb.stat_cnt[STAT_NOFREE],
             sb.perm_hits);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
